// ===== sv/mtbd_pkg.sv =====
// Shared types, constants and state codes of the MFSK tone-to-byte demapper.
package mtbd_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int FIELD_W       = 16;
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 4;
  localparam int ACC_BITS_W    = 3;
  localparam int CFG_ADDR_W    = 2;
  localparam int BPT_W         = 4;
  localparam int OUT_TDATA_W   = 16;
  localparam int FREQ_BITS_DEF = 16;

  // Most bits a data tone may carry.
  localparam logic [CNT_W-1:0] MAX_BPT   = 4'd8;
  localparam logic [CNT_W-1:0] FULL_BYTE = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_FREQ  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPACING   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LAST_FREQ = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BPT       = 2'd3;

  // Input command codes.
  localparam logic CMD_TONE  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FLUSH
  } mtbd_state_t;

  // Result of one bin search, valid while done is high.
  typedef struct packed {
    logic              done;
    logic              hit;
    logic              data_tone;  // bin two or above
    logic [BYTE_W-1:0] sym;        // low byte of bin minus two, or the bit for bins 0/1
  } srch_res_t;

  // Commands from the sequencer to the byte packer.
  typedef struct packed {
    logic push;
    logic bit_v;
    logic flush;
  } pk_cmd_t;

endpackage

// ===== sv/mtbd_bin_search.sv =====
// Iterative bin search: one bin centre compared per cycle by a shared compare unit.
module mtbd_bin_search #(
  parameter int FREQ_BITS = mtbd_pkg::FREQ_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [((FREQ_BITS < 16) ? FREQ_BITS : 16)-1:0] freq,
  input  logic [((FREQ_BITS < 16) ? FREQ_BITS : 16)-1:0] low_freq,
  input  logic [((FREQ_BITS < 16) ? FREQ_BITS : 16)-1:0] spacing,
  input  logic [((FREQ_BITS < 16) ? FREQ_BITS : 16)-1:0] last_freq,
  output mtbd_pkg::srch_res_t                        res
);
  import mtbd_pkg::*;

  localparam int FW = (FREQ_BITS < 16) ? FREQ_BITS : 16;
  // Centres run up to one spacing past the last centre, plus half a spacing.
  localparam int CW = FW + 2;

  logic          busy_r, busy_nxt;
  logic [CW-1:0] c_r, c_nxt;      // current bin centre
  logic [CW-1:0] ch_r, ch_nxt;    // centre plus half spacing
  logic [CW-1:0] fh_r, fh_nxt;    // frequency plus half spacing
  logic [CW-1:0] f_r, f_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [FW-1:0] k_r, k_nxt;
  logic [FW-1:0] sp_eff;
  logic [FW-1:0] half;
  logic [FW-1:0] k_m2;
  logic          past_last, above_f, in_win;

  // A zero spacing behaves as one.
  assign sp_eff = (spacing == '0) ? FW'(1) : spacing;
  assign half   = sp_eff >> 1;
  assign k_m2   = k_r - FW'(2);

  // Shared compare unit working on the current centre.
  assign past_last = c_r > CW'(last_freq);
  assign above_f   = fh_r < c_r;
  assign in_win    = f_r <= ch_r;

  always_comb begin
    busy_nxt = busy_r;
    c_nxt    = c_r;
    ch_nxt   = ch_r;
    fh_nxt   = fh_r;
    f_nxt    = f_r;
    sp_nxt   = sp_r;
    k_nxt    = k_r;
    res      = '0;
    if (start) begin
      busy_nxt = 1'b1;
      c_nxt    = CW'(low_freq);
      ch_nxt   = CW'(low_freq) + CW'(half);
      fh_nxt   = CW'(freq) + CW'(half);
      f_nxt    = CW'(freq);
      sp_nxt   = CW'(sp_eff);
      k_nxt    = '0;
    end else if (busy_r) begin
      priority if (past_last || above_f) begin
        busy_nxt = 1'b0;
        res.done = 1'b1;
      end else if (in_win) begin
        busy_nxt      = 1'b0;
        res.done      = 1'b1;
        res.hit       = 1'b1;
        res.data_tone = k_r > FW'(1);
        res.sym       = (k_r > FW'(1)) ? k_m2[BYTE_W-1:0] : {{(BYTE_W-1){1'b0}}, k_r[0]};
      end else begin
        c_nxt  = c_r + sp_r;
        ch_nxt = ch_r + sp_r;
        k_nxt  = k_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    c_r  <= c_nxt;
    ch_r <= ch_nxt;
    fh_r <= fh_nxt;
    f_r  <= f_nxt;
    sp_r <= sp_nxt;
    k_r  <= k_nxt;
  end

endmodule

// ===== sv/mtbd_byte_packer.sv =====
// Bit accumulator and output register that assembles and holds result bytes.
module mtbd_byte_packer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mtbd_pkg::pk_cmd_t                     cmd,
  output logic                                  can_take,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [mtbd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tuser
);
  import mtbd_pkg::*;

  logic [BYTE_W-1:0]     acc_r, acc_nxt;
  logic [ACC_BITS_W-1:0] nbits_r, nbits_nxt;
  logic                  ov_r, ov_nxt;
  logic [BYTE_W-1:0]     ob_r, ob_nxt;
  logic                  op_r, op_nxt;
  logic [CNT_W-1:0]      oc_r, oc_nxt;
  logic [BYTE_W-1:0]     shifted;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  load;

  // A new result may be loaded when the output register is empty or draining.
  assign can_take = !ov_r || out_tready;
  assign shifted  = {acc_r[BYTE_W-2:0], cmd.bit_v};
  assign cnt_inc  = {1'b0, nbits_r} + CNT_W'(1);

  always_comb begin
    acc_nxt   = acc_r;
    nbits_nxt = nbits_r;
    ob_nxt    = ob_r;
    op_nxt    = op_r;
    oc_nxt    = oc_r;
    load      = 1'b0;
    priority if (cmd.flush) begin
      // Flush emits what is held, right-aligned, then clears.
      if (nbits_r != '0) begin
        load   = 1'b1;
        ob_nxt = acc_r;
        op_nxt = 1'b1;
        oc_nxt = {1'b0, nbits_r};
      end
      acc_nxt   = '0;
      nbits_nxt = '0;
    end else if (cmd.push) begin
      if (cnt_inc == FULL_BYTE) begin
        load      = 1'b1;
        ob_nxt    = shifted;
        op_nxt    = 1'b0;
        oc_nxt    = FULL_BYTE;
        acc_nxt   = '0;
        nbits_nxt = '0;
      end else begin
        acc_nxt   = shifted;
        nbits_nxt = cnt_inc[ACC_BITS_W-1:0];
      end
    end else begin
      load = 1'b0;
    end
    // Output valid: set on load, cleared when the beat is taken.
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      nbits_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      nbits_r <= nbits_nxt;
      ov_r    <= ov_nxt;
    end
    ob_r <= ob_nxt;
    op_r <= op_nxt;
    oc_r <= oc_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_TDATA_W-BYTE_W-CNT_W){1'b0}}, oc_r, ob_r};
  assign out_tuser  = op_r;

endmodule

// ===== sv/mfsk_tone_to_byte_demapper_unit.sv =====
// Top level of the MFSK tone-to-byte demapper: registers, sequencer and units.
//
//  Channel  Direction  Content
//  in_      slave      tdata: freq_hz[15:0]; tuser: cmd
//  out_     master     tdata: byte_value[7:0], bit_count[11:8]; tuser: is_partial
//  cfg_     write      addr: register index; wdata: value
//
// A tone is accepted in the idle state and starts the bin search, whose compare unit
// tries one bin centre per cycle; the tone's bits are then shifted out one per cycle
// (one for bins 0/1, up to eight). A miss ends at the first centre above the tone or
// past the last centre. A flush passes through the flush state to the packer. Reset
// is synchronous and active low; it clears the accumulator and sets the registers to
// their reset values. A completed byte waits in the output register while the next
// item is taken; each shifted bit and each flush waits while that register holds a
// byte that out_tready has not yet taken.
module mfsk_tone_to_byte_demapper_unit #(
  parameter int FREQ_BITS = mtbd_pkg::FREQ_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mtbd_pkg::FIELD_W-1:0]         in_tdata,   // freq_hz[15:0]
  input  logic                                 in_tuser,   // cmd
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mtbd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // byte_value[7:0], bit_count[11:8]
  output logic                                 out_tuser,  // is_partial
  input  logic                                 cfg_we,
  input  logic [mtbd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mtbd_pkg::FIELD_W-1:0]         cfg_wdata
);
  import mtbd_pkg::*;

  localparam int FW = (FREQ_BITS < 16) ? FREQ_BITS : 16;

  logic [FW-1:0]     low_r, sp_r, last_r;
  logic [BPT_W-1:0]  bpt_r;
  mtbd_state_t       state_r, state_nxt;
  logic [BYTE_W-1:0] sym_r, sym_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  bpt_eff;
  logic [CNT_W-1:0]  cnt_m1;
  logic              accept;
  logic              start;
  srch_res_t         res;
  pk_cmd_t           pk;
  logic              can_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      sp_r   <= FW'(1);
      last_r <= '0;
      bpt_r  <= BPT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LOW_FREQ:  low_r  <= cfg_wdata[FW-1:0];
        REG_SPACING:   sp_r   <= cfg_wdata[FW-1:0];
        REG_LAST_FREQ: last_r <= cfg_wdata[FW-1:0];
        REG_BPT:       bpt_r  <= cfg_wdata[BPT_W-1:0];
      endcase
    end
  end

  assign bpt_eff   = (bpt_r > MAX_BPT) ? MAX_BPT : bpt_r;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cnt_m1    = cnt_r - CNT_W'(1);

  // Sequencer: next state and unit commands.
  always_comb begin
    state_nxt = state_r;
    sym_nxt   = sym_r;
    cnt_nxt   = cnt_r;
    start     = 1'b0;
    pk        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == CMD_FLUSH) begin
            state_nxt = ST_FLUSH;
          end else begin
            start     = 1'b1;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (res.done) begin
          sym_nxt = res.sym;
          cnt_nxt = res.data_tone ? bpt_eff : CNT_W'(1);
          if (res.hit && (!res.data_tone || bpt_eff != '0)) begin
            state_nxt = ST_SHIFT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        // Bits go out MSB first, one per cycle while the packer can take them.
        if (can_take) begin
          pk.push  = 1'b1;
          pk.bit_v = sym_r[cnt_m1[ACC_BITS_W-1:0]];
          cnt_nxt  = cnt_m1;
          if (cnt_m1 == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (can_take) begin
          pk.flush  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sym_r <= sym_nxt;
    cnt_r <= cnt_nxt;
  end

  mtbd_bin_search #(
    .FREQ_BITS(FREQ_BITS)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .freq      (in_tdata[FW-1:0]),
    .low_freq  (low_r),
    .spacing   (sp_r),
    .last_freq (last_r),
    .res       (res)
  );

  mtbd_byte_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (pk),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/mtbd_checker.sv =====
// Port-level checks of the demapper, bound to the top level.
module mtbd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [mtbd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic                                 out_tuser
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // A full byte always carries eight bits.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[11:8] == 4'd8)
    else $error("full byte without eight bits");

  // A partial byte holds between one and seven bits.
  a_part_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[11:8] != 4'd0 && out_tdata[11:8] < 4'd8)
    else $error("partial byte with bad bit count");

  // Padding above the bit count stays zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:12] == 4'd0)
    else $error("output padding not zero");

  // Every accepted item keeps the block busy for at least the next cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a beat");

endmodule

bind mfsk_tone_to_byte_demapper_unit mtbd_checker u_mtbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the MFSK tone-to-byte demapper unit.
`timescale 1ns / 100ps

module tb_top;
  import mtbd_pkg::*;

  // One input beat: a command and the tone frequency it carries.
  typedef struct packed {
    logic              cmd;
    logic [FIELD_W-1:0] freq;
  } tone_item_t;

  // One emitted byte as seen on the output channel.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              partial;
    logic [CNT_W-1:0]  count;
  } byte_res_t;

  localparam int DRAIN_LIMIT = 300000;
  localparam int HOLDOFF_CYCLES = 800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [FIELD_W-1:0] in_tdata = '0;    // freq_hz[15:0]
  logic in_tuser = 1'b0;                // cmd
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;    // byte_value[7:0], bit_count[11:8]
  logic out_tuser;                      // is_partial
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [FIELD_W-1:0] cfg_wdata = '0;

  // Items waiting for the driver and bytes waiting for the output.
  tone_item_t pending_items[$];
  byte_res_t  expected_bytes[$];

  // Shadow copy of the registers and of the bit accumulator.
  logic [FIELD_W-1:0] sh_low = 16'd0;
  logic [FIELD_W-1:0] sh_spacing = 16'd1;
  logic [FIELD_W-1:0] sh_last = 16'd0;
  logic [BPT_W-1:0]   sh_bpt = 4'd1;
  logic [BYTE_W-1:0]  acc_byte = '0;
  int                 acc_cnt = 0;

  int idle_pct = 7;
  int err_count = 0;
  int beats_sent = 0;
  int flushes_sent = 0;
  int bytes_checked = 0;
  int partials_seen = 0;
  int settings_used = 1;
  int hold_left = 0;

  mfsk_tone_to_byte_demapper_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock and the single reset at the start.
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Prints one mismatch line (for the first 40 only) and counts it.
  task automatic report_mismatch(input string msg);
    if (err_count < 40) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  // Number of bin centres the search may try under the current registers.
  function automatic int unsigned search_span();
    int unsigned spe;
    spe = (sh_spacing == 0) ? 1 : sh_spacing;
    if (sh_low > sh_last) return 0;
    return (sh_last - sh_low) / spe + 1;
  endfunction

  // Maps a tone to its bin and shifts its bits, or flushes; returns 1 when a byte comes out.
  function automatic bit demap_item(input logic cmd, input logic [FIELD_W-1:0] freq,
                                    output byte_res_t res);
    int unsigned spe, half, centre, bin, nbits;
    bit found, stop, emitted;
    logic [BYTE_W-1:0] sym;
    res = '0;
    emitted = 1'b0;
    if (cmd == CMD_FLUSH) begin
      if (acc_cnt != 0) begin
        res.value = acc_byte;
        res.partial = 1'b1;
        res.count = CNT_W'(acc_cnt);
        emitted = 1'b1;
      end
      acc_byte = '0;
      acc_cnt = 0;
      return emitted;
    end
    // Lowest matching bin wins; stop once every later window lies above the tone.
    spe = (sh_spacing == 0) ? 1 : sh_spacing;
    half = spe / 2;
    centre = sh_low;
    bin = 0;
    found = 1'b0;
    stop = 1'b0;
    while (!found && !stop && centre <= sh_last) begin
      if (freq + half < centre) stop = 1'b1;
      else if (freq <= centre + half) found = 1'b1;
      else begin
        centre += spe;
        bin++;
      end
    end
    if (!found) return 1'b0;
    // Bins 0 and 1 carry one bit, data bins carry bin-2 MSB first.
    if (bin < 2) begin
      nbits = 1;
      sym = BYTE_W'(bin);
    end else begin
      nbits = (sh_bpt > MAX_BPT) ? MAX_BPT : sh_bpt;
      sym = BYTE_W'(bin - 2);
    end
    for (int i = int'(nbits) - 1; i >= 0; i--) begin
      acc_byte = {acc_byte[BYTE_W-2:0], sym[i]};
      acc_cnt++;
      if (acc_cnt == 8) begin
        res.value = acc_byte;
        res.partial = 1'b0;
        res.count = FULL_BYTE;
        emitted = 1'b1;
        acc_byte = '0;
        acc_cnt = 0;
      end
    end
    return emitted;
  endfunction

  // Driver: offers pending items and predicts each one as it is accepted.
  always @(posedge clk) begin
    byte_res_t res;
    tone_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (demap_item(in_tuser, in_tdata, res)) expected_bytes = {expected_bytes, res};
        beats_sent++;
        if (in_tuser == CMD_FLUSH) flushes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.freq;
          in_tuser <= nxt.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output beat and stalls the output at random.
  always @(posedge clk) begin
    byte_res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[BYTE_W-1:0];
        got.count = out_tdata[BYTE_W+CNT_W-1:BYTE_W];
        got.partial = out_tuser;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte 0x%02h", got.value));
        end else begin
          want = expected_bytes.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("byte_value 0x%02h, expected 0x%02h",
                                      got.value, want.value));
          if (got.partial !== want.partial)
            report_mismatch($sformatf("is_partial %0b, expected %0b",
                                      got.partial, want.partial));
          if (got.count !== want.count)
            report_mismatch($sformatf("bit_count %0d, expected %0d",
                                      got.count, want.count));
        end
        bytes_checked++;
        if (got.partial === 1'b1) partials_seen++;
        // Long output stalls so the block backs up onto its input.
        if (bytes_checked == 40 || bytes_checked == 160) hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic queue_item(input logic cmd, input logic [FIELD_W-1:0] freq);
    tone_item_t it;
    it.cmd = cmd;
    it.freq = freq;
    pending_items = {pending_items, it};
  endtask

  // Waits until every item is taken and every byte has come, then lets a search finish.
  task automatic settle();
    int guard;
    int unsigned gap;
    guard = 0;
    while ((pending_items.size() != 0 || in_tvalid || expected_bytes.size() != 0)
           && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      report_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      expected_bytes.delete();
    end
    gap = search_span() + 20;
    repeat (gap) @(posedge clk);
  endtask

  // Writes all four registers on back-to-back cycles and updates the shadow copy.
  task automatic set_config(input int unsigned low, input int unsigned spacing,
                            input int unsigned last, input int unsigned bpt);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_LOW_FREQ;
    cfg_wdata <= FIELD_W'(low);
    @(posedge clk);
    cfg_addr <= REG_SPACING;
    cfg_wdata <= FIELD_W'(spacing);
    @(posedge clk);
    cfg_addr <= REG_LAST_FREQ;
    cfg_wdata <= FIELD_W'(last);
    @(posedge clk);
    cfg_addr <= REG_BPT;
    cfg_wdata <= FIELD_W'(bpt);
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_low = FIELD_W'(low);
    sh_spacing = FIELD_W'(spacing);
    sh_last = FIELD_W'(last);
    sh_bpt = BPT_W'(bpt);
    settings_used++;
  endtask

  // One random register setting followed by mostly on-bin tones.
  task automatic random_phase(input int n_items);
    int unsigned sp, spe, half, nb, low, last, bpt, span;
    int f, k, off, r;
    r = $urandom_range(99);
    if (r < 10) sp = 0;
    else if (r < 40) sp = $urandom_range(16, 1);
    else if (r < 95) sp = $urandom_range(2000, 17);
    else sp = $urandom_range(65535, 20000);
    spe = (sp == 0) ? 1 : sp;
    half = spe / 2;
    nb = $urandom_range(260, 1);
    span = spe * nb;
    low = (span >= 65535) ? $urandom_range(3000) : $urandom_range(65535 - span);
    last = low + spe * (nb - 1) + $urandom_range(spe - 1);
    if (last > 65535) last = 65535;
    if ($urandom_range(3) == 0) bpt = $urandom_range(15);
    else bpt = $urandom_range(8, 1);
    set_config(low, sp, last, bpt);
    nb = search_span();
    repeat (n_items) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_item(CMD_FLUSH, FIELD_W'($urandom));
      end else if (r < 16) begin
        queue_item(CMD_TONE, FIELD_W'($urandom));
      end else begin
        k = $urandom_range(nb);
        off = int'($urandom_range(2 * half + 2)) - int'(half) - 1;
        f = int'(low) + k * int'(spe) + off;
        if (f < 0) f = 0;
        if (f > 65535) f = 65535;
        queue_item(CMD_TONE, FIELD_W'(f));
      end
    end
    settle();
  endtask

  // Stimulus: directed settings first, then random settings.
  initial begin
    @(posedge rst_n);
    repeat (2) @(posedge clk);

    // Reset registers: a single bin at 0 Hz, a miss, a flush with bits and an empty flush.
    queue_item(CMD_TONE, 16'd0);
    queue_item(CMD_TONE, 16'hFFFF);
    queue_item(CMD_FLUSH, 16'd0);
    queue_item(CMD_FLUSH, 16'hFFFF);
    settle();

    // Even spacing: touching windows go to the lower bin, edges just inside and outside.
    set_config(1000, 100, 2000, 3);
    queue_item(CMD_TONE, 16'd950);
    queue_item(CMD_TONE, 16'd1050);
    queue_item(CMD_TONE, 16'd1051);
    queue_item(CMD_TONE, 16'd1250);
    queue_item(CMD_TONE, 16'd2050);
    queue_item(CMD_TONE, 16'd2051);
    queue_item(CMD_TONE, 16'd949);
    queue_item(CMD_FLUSH, 16'd0);
    settle();

    // Zero spacing acts as one, oversized bits per tone acts as eight, full range of bins.
    set_config(0, 0, 65535, 15);
    queue_item(CMD_TONE, 16'd0);
    queue_item(CMD_TONE, 16'd257);
    queue_item(CMD_TONE, 16'hFFFF);
    queue_item(CMD_FLUSH, 16'd0);
    settle();

    // Low, spacing and last at their top values: one wide bin at the top of the band.
    set_config(65535, 65535, 65535, 0);
    queue_item(CMD_TONE, 16'd32767);
    queue_item(CMD_TONE, 16'd32768);
    queue_item(CMD_TONE, 16'hFFFF);
    settle();

    // Window reaching below 0 Hz and data tones that carry no bits.
    set_config(5, 12, 100, 0);
    queue_item(CMD_TONE, 16'd0);
    queue_item(CMD_TONE, 16'd29);
    queue_item(CMD_TONE, 16'd17);
    queue_item(CMD_FLUSH, 16'd0);
    settle();

    // Random settings; one of them runs with no idling on either side.
    for (int p = 0; p < 9; p++) begin
      idle_pct = (p == 2) ? 0 : 7;
      random_phase(115);
    end
    idle_pct = 7;

    $display("Run covered %0d input beats (%0d flushes) over %0d register settings.",
             beats_sent, flushes_sent, settings_used);
    $display("Checked %0d output bytes, %0d of them partial.", bytes_checked, partials_seen);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== mfsk_tone_to_byte_demapper_unit.f =====
sv/mtbd_pkg.sv
sv/mtbd_bin_search.sv
sv/mtbd_byte_packer.sv
sv/mfsk_tone_to_byte_demapper_unit.sv
sv/mtbd_checker.sv
test/tb_top.sv
